[rtl/core/des_pkg.sv]
// des_pkg: shared types, permutation tables, s-boxes and round helpers
// for the des block cipher pipeline. no dependencies.
package des_pkg;

    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned NUM_STAGES = NUM_ROUNDS + 1;

    localparam logic [3:0] PADDR_KEY_IDX = 4'd0;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        decrypt;
    } des_stage_t;

    typedef struct packed {
        logic valid;
    } des_hs_t;

    localparam logic [6:0] IP_TBL [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TBL [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] EXP_TBL [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TBL [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] PC1_TBL [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TBL [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // running total of the per-round left rotations 1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1
    localparam logic [4:0] ROT_TOTAL [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    localparam logic [3:0] SBOX_TBL [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    // des bit n (1 = msb) of a w-bit word sits at index w - n
    function automatic logic [63:0] ip_perm(input logic [63:0] src);
        logic [63:0] res;
        res = '0;
        for (int k = 0; k < 64; k++)
            res[6'(63 - k)] = src[6'(64 - int'(IP_TBL[k]))];
        return res;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] src);
        logic [63:0] res;
        res = '0;
        for (int k = 0; k < 64; k++)
            res[6'(63 - k)] = src[6'(64 - int'(FP_TBL[k]))];
        return res;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] half,
                                            input logic [47:0] rk);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] sub;
        logic [31:0] res;
        x   = '0;
        sub = '0;
        res = '0;
        for (int k = 0; k < 48; k++)
            x[6'(47 - k)] = half[5'(32 - int'(EXP_TBL[k]))];
        x = x ^ rk;
        for (int b = 0; b < 8; b++)
        begin
            six = x[6'(47 - 6 * b) -: 6];
            sub[5'(31 - 4 * b) -: 4] = SBOX_TBL[b][{six[5], six[0], six[4:1]}];
        end
        for (int k = 0; k < 32; k++)
            res[5'(31 - k)] = sub[5'(32 - int'(P_TBL[k]))];
        return res;
    endfunction

    // subkey of one round: pc1, total rotation up to that round, pc2 (pure wiring)
    function automatic logic [47:0] round_key(input logic [63:0] key,
                                              input logic [3:0]  rnd);
        logic [55:0] cd;
        logic [55:0] c_dbl;
        logic [55:0] d_dbl;
        logic [55:0] rot;
        logic [47:0] res;
        cd  = '0;
        res = '0;
        for (int k = 0; k < 56; k++)
            cd[6'(55 - k)] = key[6'(64 - int'(PC1_TBL[k]))];
        c_dbl = {cd[55:28], cd[55:28]} << ROT_TOTAL[rnd];
        d_dbl = {cd[27:0], cd[27:0]} << ROT_TOTAL[rnd];
        rot   = {c_dbl[55:28], d_dbl[55:28]};
        for (int k = 0; k < 48; k++)
            res[6'(47 - k)] = rot[6'(56 - int'(PC2_TBL[k]))];
        return res;
    endfunction

endpackage

[rtl/core/des_apb_regs.sv]
// des_apb_regs: apb configuration port holding the 64-bit cipher key
// depends on des_pkg
module des_apb_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] cipher_key
);

    logic [63:0] key_reg;
    logic [63:0] key_next;
    logic        key_sel;

    // register index is paddr[3]
    assign key_sel = ({paddr[3], 3'b000} == des_pkg::PADDR_KEY_IDX);
    assign pready  = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (psel && penable && pwrite && pready && key_sel)
            key_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else
            key_reg <= key_next;
    end

    assign prdata     = key_sel ? key_reg : 64'd0;
    assign cipher_key = key_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && key_sel) |=> (key_reg == $past(pwdata)))
        else $error("key write not taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(psel && penable && pwrite) |=> $stable(key_reg))
        else $error("key changed without a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !key_sel) |=> $stable(key_reg))
        else $error("write to unmapped address changed key");

endmodule

[rtl/core/des_round.sv]
// des_round: one registered feistel round of the cipher pipeline
// depends on des_pkg
module des_round
(
    input  logic                clk,
    input  logic                rst_n,
    input  des_pkg::des_hs_t    up_hs,
    output logic                up_ready,
    input  des_pkg::des_stage_t up_data,
    input  logic [47:0]         enc_key,
    input  logic [47:0]         dec_key,
    output des_pkg::des_stage_t dn_data,
    output logic                dn_valid,
    input  logic                dn_ready
);

    des_pkg::des_stage_t data_reg;
    des_pkg::des_stage_t data_next;
    logic                valid_reg;
    logic                valid_next;
    logic [47:0]         rk;
    logic                load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_hs.valid && up_ready;
    assign rk       = up_data.decrypt ? dec_key : enc_key;

    always_comb
    begin
        data_next.left    = up_data.right;
        data_next.right   = up_data.left ^ des_pkg::feistel(up_data.right, rk);
        data_next.decrypt = up_data.decrypt;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
            valid_next = up_hs.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_data  = data_reg;
    assign dn_valid = valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dn_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled round stage lost its word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (up_hs.valid && up_ready) |=> valid_reg)
        else $error("accepted word not held");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> up_ready)
        else $error("empty stage not ready");

endmodule

[rtl/core/des_block_cipher.sv]
// des_block_cipher: top level of the pipelined des engine
// depends on des_pkg, des_apb_regs, des_round
//
// usage
//   s_tvalid/s_tready/s_tdata/s_tuser carry input words: a 64-bit block and
//   the decrypt flag (0 encrypt, 1 decrypt). m_tvalid/m_tready/m_tdata carry
//   the 64-bit result block, one per input word, in input order.
//   the key is written over apb at byte address 0 (64-bit pwdata); it may
//   only change while no word is in flight.
//   pipeline: 17 register stages (one input stage with the initial
//   permutation, then one per round; the final permutation is wiring on the
//   last stage). m_tvalid rises once the word has passed the input register
//   and every round register. throughput: one block per cycle while m_tready
//   stays high, set by the one-round-per-stage pipeline.
//   subkeys are wired from the key register through pc1, rotations and pc2.
//   reset clears all stage valid bits and the key to zero.
//   when m_tready is low each full stage holds its word; empty stages keep
//   filling, so up to 17 words are taken before s_tready drops.
module des_block_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // data_block
    input  logic        s_tuser,   // decrypt
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_block
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned NR = des_pkg::NUM_ROUNDS;

    logic [63:0]         cipher_key;
    logic [47:0]         sub_key [NR];
    des_pkg::des_stage_t stage_data [des_pkg::NUM_STAGES];
    logic                stage_valid [des_pkg::NUM_STAGES];
    logic                stage_ready [des_pkg::NUM_STAGES];

    des_pkg::des_stage_t in_reg;
    des_pkg::des_stage_t in_next;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [63:0]         ip_block;

    des_apb_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cipher_key (cipher_key)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NR; gi++)
        begin : g_key
            assign sub_key[gi] = des_pkg::round_key(cipher_key, 4'(gi));
        end
    endgenerate

    // input stage with initial permutation
    assign ip_block = des_pkg::ip_perm(s_tdata);
    assign s_tready = !in_valid_reg || stage_ready[0];

    always_comb
    begin
        in_next.left    = ip_block[63:32];
        in_next.right   = ip_block[31:0];
        in_next.decrypt = s_tuser;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= in_next;
    end

    assign stage_data[0]  = in_reg;
    assign stage_valid[0] = in_valid_reg;

    generate
        for (gi = 0; gi < NR; gi++)
        begin : g_round
            des_pkg::des_hs_t up_hs;
            logic             dn_ready;

            assign up_hs.valid = stage_valid[gi];

            if (gi == NR - 1)
            begin : g_last
                assign dn_ready = stage_ready[NR];
            end
            else
            begin : g_mid
                assign dn_ready = stage_ready[gi + 1];
            end

            des_round u_round
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_hs    (up_hs),
                .up_ready (stage_ready[gi]),
                .up_data  (stage_data[gi]),
                .enc_key  (sub_key[gi]),
                .dec_key  (sub_key[NR - 1 - gi]),
                .dn_data  (stage_data[gi + 1]),
                .dn_valid (stage_valid[gi + 1]),
                .dn_ready (dn_ready)
            );
        end
    endgenerate

    assign stage_ready[NR] = m_tready;

    // swap halves, then inverse permutation
    assign m_tvalid = stage_valid[NR];
    assign m_tdata  = des_pkg::fp_perm({stage_data[NR].right, stage_data[NR].left});

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !stage_ready[0]) |=> (in_valid_reg && $stable(in_reg)))
        else $error("stalled input stage lost its word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[NR] && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
